// ----- src/led_current_pid_pwm_step_macros.svh -----
// Assertion macros shared by the RTL of the LED current regulator.
`ifndef LED_CURRENT_PID_PWM_STEP_MACROS_SVH
`define LED_CURRENT_PID_PWM_STEP_MACROS_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante.
`define LCPPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LCPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCPPS_ASSERT_NOW(lbl, ante, cons, msg)
`define LCPPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/lcpps_pkg.sv -----
package lcpps_pkg;

  localparam int unsigned SP_W       = 12;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned POLE_W     = 32;
  localparam int unsigned NLP_W      = 16;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned MA_OUT_W   = 11;
  localparam int unsigned ADC_PORT_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned Q_FRAC     = 16;

  // Accumulator level above which zero current means an open load.
  localparam int unsigned DISC_THRESH_Q = 100 * 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KI       = 3'd2,
    CFG_KD       = 3'd3,
    CFG_POLE     = 3'd4,
    CFG_ILIM     = 3'd5,
    CFG_OLIM     = 3'd6,
    CFG_NOLOAD   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [SP_W-1:0]   setpoint_ma;
    logic        [GAIN_W-1:0] kp_gain;
    logic        [GAIN_W-1:0] ki_half_ts;
    logic        [GAIN_W-1:0] kd_scaled;
    logic signed [POLE_W-1:0] deriv_pole;
    logic        [GAIN_W-1:0] integ_limit;
    logic        [GAIN_W-1:0] out_limit;
    logic        [NLP_W-1:0]  no_load_pwm;
  } cfg_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_compare;
    logic             disconnect_hit;
  } pid_res_t;

endpackage

// ----- src/lcpps_pid_core.sv -----
`include "led_current_pid_pwm_step_macros.svh"

module lcpps_pid_core #(
  parameter int unsigned PWM_MAX = 200,
  parameter int unsigned MEAS_W  = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [MEAS_W-1:0]    meas_i,
  input  lcpps_pkg::cfg_t      cfg_i,
  output lcpps_pkg::pid_res_t  res_o
);

  localparam int unsigned ERR_W  = lcpps_pkg::SP_W + 1;
  localparam int unsigned DERR_W = ERR_W + 1;
  localparam int unsigned DM_W   = MEAS_W + 1;
  localparam int unsigned PROP_W = lcpps_pkg::GAIN_W + 1 + ERR_W;
  localparam int unsigned KI_W   = lcpps_pkg::GAIN_W + 1 + DERR_W;
  localparam int unsigned INT_W  = KI_W + 1;
  localparam int unsigned KD_W   = lcpps_pkg::GAIN_W + 1 + DM_W;
  localparam int unsigned PP_W   = 2 * lcpps_pkg::POLE_W;
  localparam int unsigned PSH_W  = PP_W - lcpps_pkg::Q_FRAC;
  localparam int unsigned DS_W   = PSH_W + 2;
  localparam int unsigned PS_W   = PROP_W + 2;
  localparam int unsigned PI_W   = $clog2(PWM_MAX + 1);
  localparam int unsigned AW     = PI_W + lcpps_pkg::Q_FRAC;
  localparam int unsigned ACC_W  = 34;

  localparam logic [AW-1:0]           PMAX     = {PI_W'(PWM_MAX), 16'd0};
  localparam logic signed [ACC_W-1:0] PMAX_S   = ACC_W'(PMAX);
  localparam logic signed [ACC_W-1:0] DISC_S   = ACC_W'(lcpps_pkg::DISC_THRESH_Q);
  localparam logic signed [DS_W-1:0]  I32_MAX  = DS_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [DS_W-1:0]  I32_MIN  = -DS_W'(33'sh0_8000_0000);

  logic signed [31:0]     integ_q, integ_d;
  logic signed [31:0]     dterm_q;
  logic signed [ERR_W-1:0] perr_q;
  logic [MEAS_W-1:0]      pmeas_q;
  logic [AW-1:0]          accum_q, accum_d;

  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic signed [PROP_W-1:0] prop;
  logic signed [KI_W-1:0]   ki_prod;
  logic signed [INT_W-1:0]  integ_sum, ilim_p, ilim_n;
  logic signed [31:0]       integ_cl;
  logic signed [DM_W-1:0]   dmeas;
  logic signed [KD_W-1:0]   kd_prod;
  logic signed [PP_W-1:0]   pole_prod;
  logic signed [PSH_W-1:0]  pole_sh;
  logic signed [DS_W-1:0]   dneg;
  logic signed [31:0]       d_cl;
  logic signed [PS_W-1:0]   pid_sum, olim_p, olim_n;
  logic signed [31:0]       out_cl;
  logic signed [ACC_W-1:0]  acc, acc_sel;
  logic                     hit;

  always_comb begin
    err  = ERR_W'(cfg_i.setpoint_ma) - ERR_W'(meas_i);
    derr = DERR_W'(err) - DERR_W'(perr_q);
    prop = $signed({1'b0, cfg_i.kp_gain}) * err;

    ki_prod   = $signed({1'b0, cfg_i.ki_half_ts}) * derr;
    integ_sum = INT_W'(integ_q) + INT_W'(ki_prod);
    ilim_p    = INT_W'(cfg_i.integ_limit);
    ilim_n    = -ilim_p;
    priority if (integ_sum > ilim_p) begin
      integ_cl = 32'(ilim_p);
    end else if (integ_sum < ilim_n) begin
      integ_cl = 32'(ilim_n);
    end else begin
      integ_cl = integ_sum[31:0];
    end

    dmeas     = DM_W'(meas_i) - DM_W'(pmeas_q);
    kd_prod   = $signed({1'b0, cfg_i.kd_scaled}) * dmeas;
    pole_prod = cfg_i.deriv_pole * dterm_q;
    pole_sh   = pole_prod[PP_W-1:lcpps_pkg::Q_FRAC];
    dneg      = -(DS_W'(kd_prod) + DS_W'(pole_sh));
    priority if (dneg > I32_MAX) begin
      d_cl = 32'(I32_MAX);
    end else if (dneg < I32_MIN) begin
      d_cl = 32'(I32_MIN);
    end else begin
      d_cl = dneg[31:0];
    end

    pid_sum = PS_W'(prop) + PS_W'(integ_cl) + PS_W'(d_cl);
    olim_p  = PS_W'(cfg_i.out_limit);
    olim_n  = -olim_p;
    priority if (pid_sum > olim_p) begin
      out_cl = 32'(olim_p);
    end else if (pid_sum < olim_n) begin
      out_cl = 32'(olim_n);
    end else begin
      out_cl = pid_sum[31:0];
    end

    acc = ACC_W'(accum_q) + ACC_W'(out_cl);
    hit = (meas_i == '0) && (cfg_i.setpoint_ma != '0) && (acc > DISC_S);
    acc_sel = hit ? ACC_W'({cfg_i.no_load_pwm, 16'd0}) : acc;
    priority if (acc_sel > PMAX_S) begin
      accum_d = PMAX;
    end else if (acc_sel < 0) begin
      accum_d = '0;
    end else begin
      accum_d = acc_sel[AW-1:0];
    end
    integ_d = hit ? '0 : integ_cl;

    res_o.pwm_compare    = (cfg_i.setpoint_ma == '0) ? '0
                         : lcpps_pkg::PWM_W'(accum_d[AW-1:lcpps_pkg::Q_FRAC]);
    res_o.disconnect_hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      dterm_q <= '0;
      perr_q  <= '0;
      pmeas_q <= '0;
      accum_q <= '0;
    end else if (step_i) begin
      integ_q <= integ_d;
      dterm_q <= d_cl;
      perr_q  <= err;
      pmeas_q <= meas_i;
      accum_q <= accum_d;
    end
  end

  `LCPPS_ASSERT_NOW(a_accum_max, 1'b1, accum_q <= PMAX, "accumulator above PWM_MAX")
  `LCPPS_ASSERT_NEXT(a_hit_clr, step_i && res_o.disconnect_hit, integ_q == '0, "integrator kept on disconnect")
  `LCPPS_ASSERT_NEXT(a_hit_meas, step_i && res_o.disconnect_hit, pmeas_q == '0, "disconnect with current")

endmodule

// ----- src/led_current_pid_pwm_step.sv -----
// Channel  Handshake                    Payload
// in       in_valid_i / in_ready_o      adc_current_count_i
// out      out_valid_o / out_ready_i    pwm_compare_o, measured_ma_o, disconnect_hit_o
// cfg      cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One word per cycle while the output is not stalled; a taken word passes the input register
// and then the result register before it reaches the output. The input register (current
// scaled to mA) and the result register lie around the combinational PID and accumulator update.
// Reset clears the configuration, the controller state and both valid flags.
// A stalled output holds the result register, and the input register behind it once that is full.
`include "led_current_pid_pwm_step_macros.svh"

module led_current_pid_pwm_step #(
  parameter int unsigned PWM_MAX  = 200,
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcpps_pkg::ADC_PORT_W-1:0]    adc_current_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lcpps_pkg::PWM_W-1:0]         pwm_compare_o,
  output logic [lcpps_pkg::MA_OUT_W-1:0]      measured_ma_o,
  output logic                                disconnect_hit_o,
  input  logic                                cfg_we_i,
  input  logic [lcpps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcpps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CW       = (ADC_BITS < lcpps_pkg::ADC_PORT_W) ? ADC_BITS
                                   : lcpps_pkg::ADC_PORT_W;
  localparam int unsigned MEAS_W   = CW - 1;
  localparam int unsigned N_W      = CW + 1;
  localparam int unsigned RECIP    = 209716;
  localparam int unsigned RECIP_W  = 18;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned NP_W     = N_W + RECIP_W;
  localparam int unsigned MEAS_MAX = ((2 ** CW - 1) * 2) / 5;

  lcpps_pkg::cfg_t     cfg_q;
  lcpps_pkg::pid_res_t res;

  logic [NP_W-1:0]   nprod;
  logic [MEAS_W-1:0] meas_in;
  logic              s1_valid_q;
  logic [MEAS_W-1:0] meas_q;
  logic              out_valid_q;
  logic [MEAS_W-1:0] meas_out_q;
  logic [lcpps_pkg::PWM_W-1:0] pwm_q;
  logic              hit_q;
  logic              adv;
  logic              step;

  // count * 2 / 5 by reciprocal, exact for the whole count range
  assign nprod   = NP_W'({adc_current_count_i[CW-1:0], 1'b0}) * NP_W'(RECIP);
  assign meas_in = nprod[RECIP_SH +: MEAS_W];

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign step       = adv && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lcpps_pkg::cfg_idx_e'(cfg_idx_i))
        lcpps_pkg::CFG_SETPOINT: cfg_q.setpoint_ma <= cfg_wdata_i[lcpps_pkg::SP_W-1:0];
        lcpps_pkg::CFG_KP:       cfg_q.kp_gain     <= cfg_wdata_i[lcpps_pkg::GAIN_W-1:0];
        lcpps_pkg::CFG_KI:       cfg_q.ki_half_ts  <= cfg_wdata_i[lcpps_pkg::GAIN_W-1:0];
        lcpps_pkg::CFG_KD:       cfg_q.kd_scaled   <= cfg_wdata_i[lcpps_pkg::GAIN_W-1:0];
        lcpps_pkg::CFG_POLE:     cfg_q.deriv_pole  <= $signed(cfg_wdata_i);
        lcpps_pkg::CFG_ILIM:     cfg_q.integ_limit <= cfg_wdata_i[lcpps_pkg::GAIN_W-1:0];
        lcpps_pkg::CFG_OLIM:     cfg_q.out_limit   <= cfg_wdata_i[lcpps_pkg::GAIN_W-1:0];
        lcpps_pkg::CFG_NOLOAD:   cfg_q.no_load_pwm <= cfg_wdata_i[lcpps_pkg::NLP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      meas_q <= meas_in;
    end
    if (step) begin
      meas_out_q <= meas_q;
      pwm_q      <= res.pwm_compare;
      hit_q      <= res.disconnect_hit;
    end
  end

  lcpps_pid_core #(
    .PWM_MAX (PWM_MAX),
    .MEAS_W  (MEAS_W)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .meas_i (meas_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign pwm_compare_o    = pwm_q;
  assign measured_ma_o    = lcpps_pkg::MA_OUT_W'(meas_out_q);
  assign disconnect_hit_o = hit_q;

  `LCPPS_ASSERT_NEXT(a_take_fill, in_valid_i && in_ready_o, s1_valid_q, "taken word lost")
  `LCPPS_ASSERT_NEXT(a_step_out, step, out_valid_q, "stepped word not shown")
  `LCPPS_ASSERT_NOW(a_meas_max, out_valid_o, measured_ma_o <= MEAS_MAX, "current out of range")

endmodule

// ----- tb/sv/tb.sv -----
module tb;

  localparam int unsigned PWM_MAX_C   = 200;
  localparam int          N_PHASES    = 12;
  localparam int          PHASE_ITEMS = 104;
  localparam int          LIMIT       = 800000;
  localparam longint      I32_MIN     = -(longint'(1) <<< 31);
  localparam longint      I32_MAX     = (longint'(1) <<< 31) - 1;

  typedef struct packed {
    logic [lcpps_pkg::PWM_W-1:0]    pwm_compare;
    logic [lcpps_pkg::MA_OUT_W-1:0] measured_ma;
    logic                           disconnect_hit;
  } ctrl_out_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [lcpps_pkg::ADC_PORT_W-1:0] adc_current_count_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [lcpps_pkg::PWM_W-1:0]      pwm_compare_o;
  logic [lcpps_pkg::MA_OUT_W-1:0]   measured_ma_o;
  logic                             disconnect_hit_o;
  logic                             cfg_we_i = 1'b0;
  logic [lcpps_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [lcpps_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  lcpps_pkg::cfg_t       gains = '0;
  int                    integ_q = 0;
  int                    dterm_q = 0;
  int                    last_err = 0;
  int                    last_ma = 0;
  int unsigned           accum_q = 0;

  logic [lcpps_pkg::ADC_PORT_W-1:0] adc_samples_q[$];
  ctrl_out_t             ctrl_out_q[$];

  int                    fail_cnt = 0;
  int                    cycle_cnt = 0;
  int                    send_gap = 0;
  int                    send_run = 0;
  int                    recv_stall = 0;
  int                    recv_run = 0;
  logic                  send_nv;
  logic                  drain_req = 1'b0;

  led_current_pid_pwm_step #(
    .PWM_MAX (PWM_MAX_C),
    .ADC_BITS(12)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .adc_current_count_i(adc_current_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pwm_compare_o      (pwm_compare_o),
    .measured_ma_o      (measured_ma_o),
    .disconnect_hit_o   (disconnect_hit_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial forever #6 clk_i = ~clk_i;

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic void regulator_step(input logic [lcpps_pkg::ADC_PORT_W-1:0] count);
    longint    ma, err, prop, integ, deriv, pid, acc, ilim, olim;
    int        pole;
    logic      hit;
    ctrl_out_t r;
    pole  = gains.deriv_pole;
    ilim  = longint'(gains.integ_limit);
    olim  = longint'(gains.out_limit);
    ma    = longint'(count) * 2 / 5;
    err   = longint'(gains.setpoint_ma) - ma;
    prop  = longint'(gains.kp_gain) * err;
    integ = longint'(integ_q) + longint'(gains.ki_half_ts) * (err - longint'(last_err));
    integ = sat(integ, -ilim, ilim);
    deriv = longint'(gains.kd_scaled) * (ma - longint'(last_ma))
            + ((longint'(pole) * longint'(dterm_q)) >>> lcpps_pkg::Q_FRAC);
    deriv = sat(-deriv, I32_MIN, I32_MAX);
    dterm_q = int'(deriv);
    pid = sat(prop + integ + deriv, -olim, olim);
    last_err = int'(err);
    last_ma  = int'(ma);
    acc = longint'(accum_q) + pid;
    hit = 1'b0;
    if (ma == 0 && gains.setpoint_ma != 0 && acc > longint'(lcpps_pkg::DISC_THRESH_Q)) begin
      acc   = longint'(gains.no_load_pwm) <<< lcpps_pkg::Q_FRAC;
      integ = 0;
      hit   = 1'b1;
    end
    integ_q = int'(integ);
    acc = sat(acc, 0, longint'(PWM_MAX_C) <<< lcpps_pkg::Q_FRAC);
    accum_q = acc[31:0];
    r.pwm_compare    = (gains.setpoint_ma == 0) ? '0 : accum_q[31:16];
    r.measured_ma    = ma[lcpps_pkg::MA_OUT_W-1:0];
    r.disconnect_hit = hit;
    ctrl_out_q.push_back(r);
  endfunction

  function automatic int idle_len(inout int run);
    int unsigned r;
    if (run > 0) begin
      run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [lcpps_pkg::GAIN_W-1:0] rand_gain(input int unsigned typ_hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 22) return '1;
    if (r < 40) return lcpps_pkg::GAIN_W'($urandom());
    return lcpps_pkg::GAIN_W'($urandom_range(0, typ_hi));
  endfunction

  function automatic lcpps_pkg::cfg_t pick_cfg(input int p);
    lcpps_pkg::cfg_t c;
    int unsigned     r;
    c = '0;
    case (p)
      0: begin
        c.setpoint_ma = '1;
        c.kp_gain     = '1;
        c.ki_half_ts  = '1;
        c.kd_scaled   = '1;
        c.deriv_pole  = 32'sh7FFF_FFFF;
        c.integ_limit = '1;
        c.out_limit   = '1;
        c.no_load_pwm = '1;
      end
      1: begin
        c.setpoint_ma = 12'd1;
        c.kp_gain     = 31'd1;
        c.ki_half_ts  = '1;
        c.deriv_pole  = 32'sh8000_0000;
        c.integ_limit = '1;
        c.out_limit   = '1;
      end
      2: c = '0;
      default: begin
        r = $urandom_range(0, 99);
        if (r < 10) c.setpoint_ma = '0;
        else if (r < 20) c.setpoint_ma = '1;
        else if (r < 30) c.setpoint_ma = lcpps_pkg::SP_W'($urandom());
        else c.setpoint_ma = lcpps_pkg::SP_W'($urandom_range(1, 1638));
        c.kp_gain     = rand_gain(32'h0004_0000);
        c.ki_half_ts  = rand_gain(32'h0004_0000);
        c.kd_scaled   = rand_gain(32'h0004_0000);
        c.integ_limit = rand_gain(32'h00C8_0000);
        c.out_limit   = rand_gain(32'h00C8_0000);
        r = $urandom_range(0, 99);
        if (r < 12) c.deriv_pole = '0;
        else if (r < 20) c.deriv_pole = 32'sh7FFF_FFFF;
        else if (r < 28) c.deriv_pole = 32'sh8000_0000;
        else if (r < 40) c.deriv_pole = $urandom();
        else c.deriv_pole = int'($urandom_range(0, 131072)) - 65536;
        r = $urandom_range(0, 99);
        if (r < 10) c.no_load_pwm = '1;
        else if (r < 20) c.no_load_pwm = lcpps_pkg::NLP_W'($urandom());
        else c.no_load_pwm = lcpps_pkg::NLP_W'($urandom_range(0, 250));
      end
    endcase
    return c;
  endfunction

  function automatic logic [lcpps_pkg::ADC_PORT_W-1:0] sample_for(input int unsigned seg);
    int center;
    center = int'(gains.setpoint_ma) * 5 / 2;
    if (seg < 55) begin
      center = center + int'($urandom_range(0, 80)) - 40;
      return lcpps_pkg::ADC_PORT_W'(sat(center, 0, 4095));
    end
    if (seg < 70) return lcpps_pkg::ADC_PORT_W'($urandom_range(0, 2));
    if (seg < 90) return lcpps_pkg::ADC_PORT_W'($urandom_range(0, 4095));
    return $urandom_range(0, 1) ? 12'd4095 : 12'd3;
  endfunction

  task automatic write_reg(input lcpps_pkg::cfg_idx_e idx,
                           input logic [lcpps_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
  endtask

  task automatic load_cfg(input lcpps_pkg::cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(lcpps_pkg::CFG_SETPOINT, {junk[31:12], c.setpoint_ma});
    write_reg(lcpps_pkg::CFG_KP, {junk[0], c.kp_gain});
    write_reg(lcpps_pkg::CFG_KI, {junk[1], c.ki_half_ts});
    write_reg(lcpps_pkg::CFG_KD, {junk[2], c.kd_scaled});
    write_reg(lcpps_pkg::CFG_POLE, c.deriv_pole);
    write_reg(lcpps_pkg::CFG_ILIM, {junk[3], c.integ_limit});
    write_reg(lcpps_pkg::CFG_OLIM, {junk[4], c.out_limit});
    write_reg(lcpps_pkg::CFG_NOLOAD, {junk[31:16], c.no_load_pwm});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gains = c;
  endtask

  task automatic wait_idle();
    while (adc_samples_q.size() != 0 || in_valid_i || ctrl_out_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic note_fail(input string what);
    if (fail_cnt < 10) $display("mismatch: %s", what);
    fail_cnt++;
  endtask

  // hold the word until taken, then pick the next gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i          <= 1'b0;
      adc_current_count_i <= '0;
      send_gap = 0;
    end else begin
      send_nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        regulator_step(adc_current_count_i);
        send_nv  = 1'b0;
        send_gap = idle_len(send_run);
        if ($urandom_range(0, 299) == 0) drain_req = 1'b1;
      end
      if (!send_nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (drain_req) begin
          if (ctrl_out_q.size() == 0) drain_req = 1'b0;
        end else if (adc_samples_q.size() != 0) begin
          adc_current_count_i <= adc_samples_q.pop_front();
          send_nv = 1'b1;
        end
      end
      in_valid_i <= send_nv;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ctrl_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (ctrl_out_q.size() == 0) begin
          note_fail($sformatf("unexpected word pwm=%0d ma=%0d hit=%0b",
                              pwm_compare_o, measured_ma_o, disconnect_hit_o));
        end else begin
          want = ctrl_out_q.pop_front();
          if (pwm_compare_o !== want.pwm_compare || measured_ma_o !== want.measured_ma ||
              disconnect_hit_o !== want.disconnect_hit)
            note_fail($sformatf("exp pwm=%0d ma=%0d hit=%0b got pwm=%0d ma=%0d hit=%0b",
                                want.pwm_compare, want.measured_ma, want.disconnect_hit,
                                pwm_compare_o, measured_ma_o, disconnect_hit_o));
        end
        recv_stall = idle_len(recv_run);
      end else if (!out_valid_o && $urandom_range(0, 15) == 0) begin
        recv_stall = idle_len(recv_run);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    lcpps_pkg::cfg_t c;
    int unsigned     seg;
    int              len;
    int              n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    adc_samples_q = '{12'd0, 12'd1, 12'd2, 12'd3, 12'hAAA, 12'h555, 12'd2048, 12'd4095};
    wait_idle();

    c = '0;
    c.setpoint_ma = 12'd500;
    c.kp_gain     = 31'h0001_0000;
    c.ki_half_ts  = 31'h0000_8000;
    c.kd_scaled   = 31'h0000_4000;
    c.deriv_pole  = 32'sh0000_C000;
    c.integ_limit = 31'h0064_0000;
    c.out_limit   = 31'h0010_0000;
    c.no_load_pwm = 16'd50;
    load_cfg(c);
    adc_samples_q.push_back(12'd1250);
    repeat (10) adc_samples_q.push_back(12'd0);
    adc_samples_q.push_back(12'd4095);
    adc_samples_q.push_back(12'd4095);
    adc_samples_q.push_back(12'd3);
    adc_samples_q.push_back(12'd2);
    adc_samples_q.push_back(12'd1);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      load_cfg(pick_cfg(p));
      n = 0;
      while (n < PHASE_ITEMS) begin
        seg = $urandom_range(0, 99);
        len = $urandom_range(1, 20);
        repeat (len) begin
          adc_samples_q.push_back(sample_for(seg));
          n++;
        end
      end
      if (p == 3) begin
        while (adc_samples_q.size() > n / 2) @(posedge clk_i);
        drain_req = 1'b1;
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
